>>> hdl/qtr_pkg.sv
package qtr_pkg;

  localparam int AMT_W = 48;
  localparam int IDX_W = 11;
  localparam int LC_W = 7;
  localparam int CPL_W = 6;
  localparam int WT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GRAD_SHIFT = 8;
  localparam int PEN_SHIFT = 25;

  localparam int DEF_MAX_COMPONENTS = 32;
  localparam int DEF_MAX_LEVELS = 64;
  localparam int DEF_VALUE_WIDTH = 24;

  localparam logic [AMT_W-1:0] AMT_MAX = {1'b0, {(AMT_W-1){1'b1}}};
  localparam logic [AMT_W-1:0] AMT_MIN = {1'b1, {(AMT_W-1){1'b0}}};

  localparam logic KIND_GRADIENT = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT,
    REG_COMPONENTS,
    REG_WEIGHT_VALUE,
    REG_WEIGHT_DIFFERENCE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_PROD2,
    ST_PROD3,
    ST_UPDATE,
    ST_FLUSH_RD,
    ST_FLUSH_OUT,
    ST_TOTAL
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  function automatic logic signed [AMT_W-1:0] sat_amt(input logic signed [AMT_W:0] v);
    if (v[AMT_W] != v[AMT_W-1]) begin
      return v[AMT_W] ? AMT_MIN : AMT_MAX;
    end
    return v[AMT_W-1:0];
  endfunction

  function automatic logic [AMT_W-1:0] pen_add(input logic [AMT_W-1:0] a,
                                                input logic [AMT_W-1:0] b);
    logic [AMT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, AMT_MAX}) ? AMT_MAX : s[AMT_W-1:0];
  endfunction

endpackage

>>> hdl/qtr_store.sv
module qtr_store
  import qtr_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COMPONENTS,
  parameter int AW = $clog2(DEF_MAX_COMPONENTS),
  parameter int CW = DEF_VALUE_WIDTH + 1
) (
  input  logic                    clk,
  input  store_ctl_t              ctl,
  input  logic [AW-1:0]           addr,
  input  logic signed [CW-1:0]    wr_centered,
  input  logic signed [AMT_W-1:0] wr_gradient,
  output logic signed [CW-1:0]    rd_centered,
  output logic signed [AMT_W-1:0] rd_gradient
);

  logic [CW-1:0] centered_mem [DEPTH];
  logic [AMT_W-1:0] gradient_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      centered_mem[addr] <= wr_centered;
      gradient_mem[addr] <= wr_gradient;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_centered <= centered_mem[addr];
      rd_gradient <= gradient_mem[addr];
    end
  end

endmodule

>>> hdl/qtr_core.sv
module qtr_core
  import qtr_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int AW = $clog2(DEF_MAX_COMPONENTS),
  parameter int LVW = $clog2(DEF_MAX_LEVELS),
  parameter int NLW = LC_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [NLW-1:0]                levels,
  input  logic [CPL_W-1:0]              components,
  input  logic [WT_W-1:0]               weight_value,
  input  logic [WT_W-1:0]               weight_difference,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] param_value,
  input  logic signed [VALUE_WIDTH-1:0] reference_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [IDX_W-1:0]              element_index,
  output logic signed [AMT_W-1:0]       amount,
  output logic                          last,
  output store_ctl_t                    store_ctl,
  output logic [AW-1:0]                 store_addr,
  output logic signed [VALUE_WIDTH:0]   store_centered,
  output logic signed [AMT_W-1:0]       store_gradient,
  input  logic signed [VALUE_WIDTH:0]   rd_centered,
  input  logic signed [AMT_W-1:0]       rd_gradient
);

  localparam int VW = VALUE_WIDTH;
  localparam int PVW = 2 * VW + 16;
  localparam int PDW = 2 * VW + 18;
  localparam int CMPW = ((PDW > AMT_W) ? PDW : AMT_W) + 1;
  localparam int CNTW = CPL_W + 1;

  function automatic logic [AMT_W-1:0] pen_clip(input logic [CMPW-1:0] v);
    return (v > CMPW'(AMT_MAX)) ? AMT_MAX : v[AMT_W-1:0];
  endfunction

  state_t state, state_next;

  logic [AW-1:0] comp;
  logic [AW-1:0] flush_k;
  logic [LVW-1:0] level;
  logic [AMT_W-1:0] penalty;

  logic signed [VW:0] d_reg;
  logic signed [VW+1:0] e_reg;
  logic signed [VW+17:0] gv_prod;
  logic signed [VW+18:0] gd_prod;
  logic [2*VW-1:0] dsq;
  logic [2*VW+1:0] esq;
  logic [PVW-1:0] pv_prod;
  logic [PDW-1:0] pd_prod;
  logic signed [AMT_W-1:0] g_reg;
  logic signed [AMT_W-1:0] newpend;

  logic [VW:0] d_abs;
  logic [VW+1:0] e_abs;
  logic signed [AMT_W:0] gv_term;
  logic signed [AMT_W:0] gd_term;

  logic out_free;
  logic level_first;
  logic end_level;
  logic end_vector;
  logic k_last;
  logic update_go;

  logic emit;
  logic emit_kind;
  logic emit_last;
  logic signed [AMT_W-1:0] emit_amount;
  logic [LVW-1:0] idx_level;
  logic [IDX_W-1:0] emit_index;

  assign out_free = !out_valid || out_ready;
  assign level_first = (level == '0);
  assign end_level = (CNTW'(comp) + CNTW'(1)) >= CNTW'(components);
  assign end_vector = ((NLW + 1)'(level) + (NLW + 1)'(1)) >= (NLW + 1)'(levels);
  assign k_last = (CNTW'(flush_k) + CNTW'(1)) >= CNTW'(components);
  assign update_go = level_first || out_free;

  assign d_abs = d_reg[VW] ? -d_reg : d_reg;
  assign e_abs = e_reg[VW+1] ? -e_reg : e_reg;
  assign gv_term = (AMT_W + 1)'(gv_prod >>> GRAD_SHIFT);
  assign gd_term = (AMT_W + 1)'(gd_prod >>> GRAD_SHIFT);

  assign idx_level = (state == ST_UPDATE) ? level - LVW'(1) : level;
  assign emit_index = IDX_W'(idx_level) * IDX_W'(components)
                    + IDX_W'((state == ST_UPDATE) ? comp : flush_k);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PROD;
      end
      ST_PROD: state_next = ST_PROD2;
      ST_PROD2: state_next = ST_PROD3;
      ST_PROD3: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (update_go) begin
          state_next = (end_level && end_vector) ? ST_FLUSH_RD : ST_IDLE;
        end
      end
      ST_FLUSH_RD: state_next = ST_FLUSH_OUT;
      ST_FLUSH_OUT: begin
        if (out_free) state_next = k_last ? ST_TOTAL : ST_FLUSH_RD;
      end
      ST_TOTAL: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    store_ctl = '0;
    store_addr = comp;
    emit = 1'b0;
    emit_kind = KIND_GRADIENT;
    emit_last = 1'b0;
    emit_amount = newpend;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        store_ctl.rd_en = in_valid;
      end
      ST_UPDATE: begin
        store_ctl.wr_en = update_go;
        emit = !level_first && out_free;
      end
      ST_FLUSH_RD: begin
        store_ctl.rd_en = 1'b1;
        store_addr = flush_k;
      end
      ST_FLUSH_OUT: begin
        emit = out_free;
        emit_amount = rd_gradient;
      end
      ST_TOTAL: begin
        emit = out_free;
        emit_kind = KIND_TOTAL;
        emit_last = 1'b1;
        emit_amount = penalty;
      end
      default: begin
      end
    endcase
  end

  assign store_centered = d_reg;
  assign store_gradient = g_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp <= '0;
      level <= '0;
      flush_k <= '0;
      penalty <= '0;
    end else begin
      case (state)
        ST_PROD3: begin
          penalty <= pen_add(penalty, pen_clip(CMPW'(pv_prod >> PEN_SHIFT)));
        end
        ST_UPDATE: begin
          if (update_go) begin
            if (!level_first) begin
              penalty <= pen_add(penalty, pen_clip(CMPW'(pd_prod >> PEN_SHIFT)));
            end
            flush_k <= '0;
            if (end_level) begin
              comp <= '0;
              if (!end_vector) level <= level + LVW'(1);
            end else begin
              comp <= comp + AW'(1);
            end
          end
        end
        ST_FLUSH_OUT: begin
          if (out_free && !k_last) flush_k <= flush_k + AW'(1);
        end
        ST_TOTAL: begin
          if (out_free) begin
            penalty <= '0;
            level <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        d_reg <= (VW + 1)'(param_value) - (VW + 1)'(reference_value);
      end
      ST_PROD: begin
        e_reg <= (VW + 2)'(d_reg) - (VW + 2)'(rd_centered);
        gv_prod <= $signed({1'b0, weight_value}) * d_reg;
        dsq <= d_abs[VW-1:0] * d_abs[VW-1:0];
      end
      ST_PROD2: begin
        gd_prod <= $signed({1'b0, weight_difference}) * e_reg;
        esq <= e_abs[VW:0] * e_abs[VW:0];
        pv_prod <= weight_value * dsq;
      end
      ST_PROD3: begin
        pd_prod <= weight_difference * esq;
        g_reg <= level_first ? sat_amt(gv_term) : sat_amt(gv_term + gd_term);
        newpend <= sat_amt((AMT_W + 1)'(rd_gradient) - gd_term);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= emit_kind;
      element_index <= (emit_kind == KIND_TOTAL) ? '0 : emit_index;
      amount <= emit_amount;
      last <= emit_last;
    end
  end

endmodule

>>> hdl/quadratic_time_regularizer.sv
// An item is accepted with a store read, then passes three registered multiply steps,
// then the store write, which also loads a gradient word from the second level on.
// A new item is taken only once the last one is through; past the first level the
// store write waits for a free output. The last item of a vector adds a flush read
// and output per component, then the total word. Synchronous reset clears the config
// registers, counters and penalty; the component stores are not cleared.
module quadratic_time_regularizer
  import qtr_pkg::*;
#(
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] param_value,
  input  logic signed [VALUE_WIDTH-1:0] reference_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [IDX_W-1:0]              element_index,
  output logic signed [AMT_W-1:0]       amount,
  output logic                          last
);

  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int NLW = ($clog2(MAX_LEVELS + 1) > LC_W) ? $clog2(MAX_LEVELS + 1) : LC_W;

  logic [LC_W-1:0] level_count;
  logic [CPL_W-1:0] components_per_level;
  logic [WT_W-1:0] weight_value;
  logic [WT_W-1:0] weight_difference;

  logic [NLW-1:0] levels;
  logic [CPL_W-1:0] components;

  store_ctl_t store_ctl;
  logic [AW-1:0] store_addr;
  logic signed [VALUE_WIDTH:0] store_centered;
  logic signed [AMT_W-1:0] store_gradient;
  logic signed [VALUE_WIDTH:0] rd_centered;
  logic signed [AMT_W-1:0] rd_gradient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LC_W'(1);
      components_per_level <= CPL_W'(1);
      weight_value <= '0;
      weight_difference <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEVEL_COUNT: level_count <= cfg_data[LC_W-1:0];
        REG_COMPONENTS: components_per_level <= cfg_data[CPL_W-1:0];
        REG_WEIGHT_VALUE: weight_value <= cfg_data[WT_W-1:0];
        REG_WEIGHT_DIFFERENCE: weight_difference <= cfg_data[WT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (level_count == '0) begin
      levels = NLW'(1);
    end else if (NLW'(level_count) > NLW'(MAX_LEVELS)) begin
      levels = NLW'(MAX_LEVELS);
    end else begin
      levels = NLW'(level_count);
    end
    if (components_per_level == '0) begin
      components = CPL_W'(1);
    end else if (components_per_level > CPL_W'(MAX_COMPONENTS)) begin
      components = CPL_W'(MAX_COMPONENTS);
    end else begin
      components = components_per_level;
    end
  end

  qtr_core #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .AW(AW),
    .LVW(LVW),
    .NLW(NLW)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .levels(levels),
    .components(components),
    .weight_value(weight_value),
    .weight_difference(weight_difference),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .param_value(param_value),
    .reference_value(reference_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .element_index(element_index),
    .amount(amount),
    .last(last),
    .store_ctl(store_ctl),
    .store_addr(store_addr),
    .store_centered(store_centered),
    .store_gradient(store_gradient),
    .rd_centered(rd_centered),
    .rd_gradient(rd_gradient)
  );

  qtr_store #(
    .DEPTH(MAX_COMPONENTS),
    .AW(AW),
    .CW(VALUE_WIDTH + 1)
  ) u_store (
    .clk(clk),
    .ctl(store_ctl),
    .addr(store_addr),
    .wr_centered(store_centered),
    .wr_gradient(store_gradient),
    .rd_centered(rd_centered),
    .rd_gradient(rd_gradient)
  );

endmodule

>>> dv/quadratic_time_regularizer_tb.sv
`timescale 1ns / 1ps

module quadratic_time_regularizer_tb
  import qtr_pkg::*;
();

  localparam int VW = DEF_VALUE_WIDTH;
  localparam int NCOMP = DEF_MAX_COMPONENTS;
  localparam int NLEV = DEF_MAX_LEVELS;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PAIRS = 50;
  localparam longint AMT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AMT_LO = -AMT_HI - 1;
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct {
    logic kind;
    logic [IDX_W-1:0] index;
    logic [AMT_W-1:0] amount;
    logic last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VW-1:0] param_value = '0;
  logic signed [VW-1:0] reference_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic result_kind;
  logic [IDX_W-1:0] element_index;
  logic signed [AMT_W-1:0] amount;
  logic last;

  quadratic_time_regularizer u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .param_value(param_value),
    .reference_value(reference_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .element_index(element_index),
    .amount(amount),
    .last(last)
  );

  always #10 clk = ~clk;

  // Predictor copy of the configuration and of the block state.
  int cfg_levels = 1;
  int cfg_comps = 1;
  longint cfg_wv = 0;
  longint cfg_wd = 0;
  longint tracked_delta [NCOMP];
  longint open_grad [NCOMP];
  longint run_penalty = 0;
  int lvl_pos = 0;
  int comp_pos = 0;

  result_word_t awaited_words [$];
  int mismatches = 0;
  int pairs_sent = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;

  function automatic int effective_count(int raw, int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic longint clamp_amt(longint v);
    if (v > AMT_HI) return AMT_HI;
    if (v < AMT_LO) return AMT_LO;
    return v;
  endfunction

  function automatic longint grad_part(longint w, longint x);
    return (w * x) >>> GRAD_SHIFT;
  endfunction

  function automatic longint pen_part(longint w, longint x);
    logic [127:0] prod;
    longint mag;
    mag = (x < 0) ? -x : x;
    prod = 128'(mag) * 128'(mag) * 128'(w);
    prod = prod >> PEN_SHIFT;
    if (prod > 128'(AMT_HI)) return AMT_HI;
    return longint'(prod[63:0]);
  endfunction

  function automatic void expect_word(logic kind, longint idx, longint amt, logic fin);
    result_word_t w;
    w.kind = kind;
    w.index = IDX_W'(idx);
    w.amount = AMT_W'(amt);
    w.last = fin;
    awaited_words.push_back(w);
  endfunction

  function automatic void accumulate_penalty(logic signed [VW-1:0] p, logic signed [VW-1:0] r);
    int nl;
    int nc;
    int lv;
    int c;
    longint d;
    longint g;
    longint e;
    longint t;
    nl = effective_count(cfg_levels, NLEV);
    nc = effective_count(cfg_comps, NCOMP);
    lv = lvl_pos;
    c = comp_pos % NCOMP;
    d = longint'(p) - longint'(r);
    g = grad_part(cfg_wv, d);
    run_penalty = clamp_amt(run_penalty + pen_part(cfg_wv, d));
    if (lv > 0) begin
      e = d - tracked_delta[c];
      t = grad_part(cfg_wd, e);
      g = clamp_amt(g + t);
      open_grad[c] = clamp_amt(open_grad[c] - t);
      run_penalty = clamp_amt(run_penalty + pen_part(cfg_wd, e));
      expect_word(KIND_GRADIENT, longint'(lv - 1) * nc + c, open_grad[c], 1'b0);
    end else begin
      g = clamp_amt(g);
    end
    open_grad[c] = g;
    tracked_delta[c] = d;
    if (c + 1 >= nc) begin
      if (lv + 1 >= nl) begin
        for (int k = 0; k < nc; k++) begin
          expect_word(KIND_GRADIENT, longint'(lv) * nc + k, open_grad[k], 1'b0);
        end
        expect_word(KIND_TOTAL, 0, run_penalty, 1'b1);
        run_penalty = 0;
        lvl_pos = 0;
      end else begin
        lvl_pos = lv + 1;
      end
      comp_pos = 0;
    end else begin
      comp_pos = c + 1;
    end
  endfunction

  function automatic logic signed [VW-1:0] draw_value();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return VW'($urandom_range(0, 1023));
      3: return {{(VW-10){1'b1}}, 10'($urandom)};
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic log_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sends one parameter/reference word and predicts its results at acceptance.
  task automatic offer_pair(logic signed [VW-1:0] p, logic signed [VW-1:0] r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    param_value <= p;
    reference_value <= r;
    do @(posedge clk); while (!in_ready);
    accumulate_penalty(p, r);
    pairs_sent++;
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEVEL_COUNT: cfg_levels = int'(data[LC_W-1:0]);
      REG_COMPONENTS: cfg_comps = int'(data[CPL_W-1:0]);
      REG_WEIGHT_VALUE: cfg_wv = longint'(data[WT_W-1:0]);
      REG_WEIGHT_DIFFERENCE: cfg_wd = longint'(data[WT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic write_setting(int l, int c, int wv, int wd);
    write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(l));
    write_reg(REG_COMPONENTS, CFG_DATA_W'(c));
    write_reg(REG_WEIGHT_VALUE, CFG_DATA_W'(wv));
    write_reg(REG_WEIGHT_DIFFERENCE, CFG_DATA_W'(wd));
  endtask

  task automatic finish_vector();
    while (lvl_pos != 0 || comp_pos != 0) offer_pair(draw_value(), draw_value());
  endtask

  task automatic test_single_level();
    write_setting(1, 1, 16'h0100, 16'h0080);
    offer_pair(VAL_MAX, VAL_MIN);
    write_reg(REG_COMPONENTS, CFG_DATA_W'(3));
    offer_pair(VAL_MIN, VAL_MAX);
    offer_pair(24'sd0, 24'sd0);
    offer_pair(VAL_MAX, 24'sd1);
  endtask

  task automatic test_extreme_values();
    write_setting(2, 2, 16'hFFFF, 16'hFFFF);
    offer_pair(VAL_MAX, VAL_MIN);
    offer_pair(VAL_MIN, VAL_MAX);
    offer_pair(VAL_MIN, VAL_MAX);
    offer_pair(VAL_MAX, VAL_MIN);
  endtask

  task automatic test_zero_weights();
    write_setting(2, 1, 0, 0);
    offer_pair(VAL_MAX, 24'sd0);
    offer_pair(24'sd0, VAL_MAX);
  endtask

  task automatic test_register_clamp();
    write_setting(0, 0, 16'h1234, 16'h8001);
    offer_pair(24'sd77, -24'sd5);
    offer_pair(-24'sd300, 24'sd299);
  endtask

  task automatic test_mid_vector_change();
    write_setting(3, 3, 16'h0200, 16'h0300);
    repeat (4) offer_pair(draw_value(), draw_value());
    write_reg(REG_WEIGHT_VALUE, 16'h0010);
    write_reg(REG_WEIGHT_DIFFERENCE, 16'h7F00);
    write_reg(REG_COMPONENTS, CFG_DATA_W'(2));
    write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(2));
    finish_vector();
  endtask

  task automatic test_output_hold();
    write_setting(4, 4, $urandom_range(0, 65535), $urandom_range(0, 65535));
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (32) offer_pair(draw_value(), draw_value());
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    write_setting(3, 2, $urandom_range(0, 65535), $urandom_range(0, 65535));
    repeat (3) offer_pair(draw_value(), draw_value());
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
    finish_vector();
  endtask

  task automatic test_penalty_saturation();
    write_setting(NLEV, 1, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < NLEV; i++) begin
      if (i % 2 == 0) offer_pair(VAL_MAX - VW'($urandom_range(0, 255)),
                                 VAL_MIN + VW'($urandom_range(0, 255)));
      else offer_pair(VAL_MIN + VW'($urandom_range(0, 255)),
                      VAL_MAX - VW'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_settings();
    int stop_at;
    int l;
    int c;
    int wv;
    int wd;
    stop_at = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: l = 0;
        1: l = 127;
        2: l = $urandom_range(5, 64);
        default: l = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0: c = 0;
        1: c = 63;
        2: c = NCOMP;
        3: c = $urandom_range(5, 31);
        default: c = $urandom_range(1, 4);
      endcase
      if (effective_count(l, NLEV) * effective_count(c, NCOMP) > 64) begin
        if (effective_count(c, NCOMP) > 4) l = $urandom_range(1, 2);
        else c = 1;
      end
      case ($urandom_range(0, 3))
        0: wv = 0;
        1: wv = 16'hFFFF;
        default: wv = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
        0: wd = 0;
        1: wd = 16'hFFFF;
        default: wd = $urandom_range(0, 65535);
      endcase
      // Bits above the register width are ignored by the block.
      write_reg(REG_LEVEL_COUNT, {9'($urandom), 7'(l)});
      write_reg(REG_COMPONENTS, {10'($urandom), 6'(c)});
      write_reg(REG_WEIGHT_VALUE, CFG_DATA_W'(wv));
      write_reg(REG_WEIGHT_DIFFERENCE, CFG_DATA_W'(wd));
      repeat ($urandom_range(1, 3)) begin
        offer_pair(draw_value(), draw_value());
        if ($urandom_range(0, 3) == 0) begin
          write_reg(REG_WEIGHT_DIFFERENCE, CFG_DATA_W'($urandom));
        end
        finish_vector();
      end
    end
  endtask

  initial begin : receiver
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    result_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        log_mismatch($sformatf("unexpected word kind %0b index %0d amount %0d",
                               result_kind, element_index, amount));
      end else begin
        w = awaited_words.pop_front();
        if (result_kind !== w.kind)
          log_mismatch($sformatf("kind %0b, want %0b", result_kind, w.kind));
        if (element_index !== w.index)
          log_mismatch($sformatf("index %0d, want %0d", element_index, w.index));
        if (amount !== w.amount)
          log_mismatch($sformatf("amount %0d, want %0d (index %0d)",
                                 amount, $signed(w.amount), w.index));
        if (last !== w.last)
          log_mismatch($sformatf("last %0b, want %0b", last, w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_level();
    test_extreme_values();
    test_zero_weights();
    test_register_clamp();
    test_mid_vector_change();
    test_output_hold();
    test_drain_pause();
    test_penalty_saturation();
    test_random_settings();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
